FILE: rtl/tpb_pkg.sv
// ---------------------------------------------------------------------------
// Trajectory preview buffer package
// Shared types and constants for the trajectory preview buffer.
// ---------------------------------------------------------------------------
package tpb_pkg;

    localparam int CAPACITY_DEF    = 32;
    localparam int PREVIEW_LEN_DEF = 24;

    localparam int WORD_W  = 32;
    localparam int SPEED_W = 16;
    localparam int CMD_W   = 3;
    localparam int RIDX_W  = 6;
    localparam int FILL_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESET    = 3'd0,
        CMD_APPEND   = 3'd1,
        CMD_BRAKE    = 3'd2,
        CMD_FINALIZE = 3'd3,
        CMD_CHECK    = 3'd4,
        CMD_READ     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        RC_OK     = 2'd0,
        RC_FAIL   = 2'd1,
        RC_NODATA = 2'd2,
        RC_END    = 2'd3
    } rc_t;

    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_BRAKING = 2'd1,
        MODE_ENDING  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_PAD,
        ST_DONE
    } state_t;

    // One stored step.
    typedef struct packed {
        logic [WORD_W-1:0]         word;
        logic signed [SPEED_W-1:0] speed;
        logic signed [SPEED_W-1:0] turn;
        logic                      last;
        logic [WORD_W-1:0]         cons;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic [WORD_W-1:0]         step_word;
        logic signed [SPEED_W-1:0] speed;
        logic signed [SPEED_W-1:0] turn_rate;
        logic                      final_flag;
        logic [WORD_W-1:0]         constraint_in;
        logic [RIDX_W-1:0]         read_index;
    } req_t;

    typedef struct packed {
        rc_t                       result_code;
        mode_t                     mode_now;
        logic [FILL_W-1:0]         fill_count;
        logic [WORD_W-1:0]         step_out;
        logic signed [SPEED_W-1:0] speed_out;
        logic signed [SPEED_W-1:0] turn_out;
        logic                      final_out;
        logic [WORD_W-1:0]         constraint_out;
    } rsp_t;

endpackage

FILE: rtl/trajectory_preview_buffer.sv
// ---------------------------------------------------------------------------
// Trajectory preview buffer
// Bounded circular store of trajectory steps with brake and finalize padding.
// ---------------------------------------------------------------------------
// Usage: a command word arrives on the req channel (req_valid, req_stall,
// req_data) and exactly one result word leaves on the rsp channel (rsp_valid,
// rsp_stall, rsp_data). Commands are reset, append, brake, finalize, check
// fill and read. The user writes the constraint word used when braking starts
// via cfg_wr_en and cfg_wr_data only while the block is idle; not enforced.
// Sequence: reset, append and failing commands pass through the execute and
// done states; read and the boundary case of check fill also pass through a
// read-wait state. Brake and finalize read one entry and then rewrite the
// store up to capacity, one entry per cycle through the single write port.
// One word is processed at a time; the next request is accepted once the
// current result sits in the output register.
// Reset empties the store, sets the mode to normal and clears the constraint
// register. While the receiver stalls, the finished result waits in the
// output register and the block can take one further request, whose result
// waits until the output register is free.
// ---------------------------------------------------------------------------
module trajectory_preview_buffer #(
    parameter int CAPACITY    = tpb_pkg::CAPACITY_DEF,
    parameter int PREVIEW_LEN = tpb_pkg::PREVIEW_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_stall,
    input  tpb_pkg::req_t               req_data,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output tpb_pkg::rsp_t               rsp_data,
    input  logic                        cfg_wr_en,
    input  logic [tpb_pkg::WORD_W-1:0]  cfg_wr_data
);
    import tpb_pkg::*;

    localparam int PTR_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int MW        = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
    localparam int FILL_MARK = PREVIEW_LEN - 1;

    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [PTR_W:0]   CAP_WIDE = (PTR_W + 1)'(CAPACITY);

    // Position of the entry at a given offset from a base slot.
    function automatic logic [PTR_W-1:0] wrap_pos(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W:0]   offs);
        logic [PTR_W:0] sum;
        sum = {1'b0, base} + offs;
        if (sum >= CAP_WIDE)
        begin
            sum = sum - CAP_WIDE;
        end
        return sum[PTR_W-1:0];
    endfunction

    entry_t mem [CAPACITY];
    entry_t mem_rdata_reg;

    logic             mem_we;
    logic [PTR_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;

    state_t           state_reg, state_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    mode_t            mode_reg, mode_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [WORD_W-1:0] cfg_reg;

    req_t             in_reg, in_next;
    rc_t              rc_reg, rc_next;
    entry_t           rd_entry_reg, rd_entry_next;
    logic [CNT_W-1:0] pad_idx_reg, pad_idx_next;
    entry_t           pad_val_reg, pad_val_next;
    logic             zero_vel_reg, zero_vel_next;
    logic             set_cons_reg, set_cons_next;
    rsp_t             rsp_data_reg, rsp_data_next;

    logic [PTR_W:0]   tail_off;
    logic [MW-1:0]    ridx_ext;
    logic [MW-1:0]    cnt_ext;
    logic [PTR_W:0]   read_off;

    always_comb
    begin
        tail_off = (PTR_W + 1)'(count_reg - 1'b1);
        ridx_ext = MW'(in_reg.read_index);
        cnt_ext  = MW'(count_reg);
        if (ridx_ext >= cnt_ext)
        begin
            read_off = tail_off;
        end
        else
        begin
            read_off = (PTR_W + 1)'(in_reg.read_index);
        end
    end

    always_comb
    begin
        entry_t pv;

        pv             = mem_rdata_reg;
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        rsp_valid_next = rsp_valid_reg;
        in_next        = in_reg;
        rc_next        = rc_reg;
        rd_entry_next  = rd_entry_reg;
        pad_idx_next   = pad_idx_reg;
        pad_val_next   = pad_val_reg;
        zero_vel_next  = zero_vel_reg;
        set_cons_next  = set_cons_reg;
        rsp_data_next  = rsp_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = wrap_pos(head_reg, (PTR_W + 1)'(pad_idx_reg));
        mem_wdata      = pad_val_reg;
        mem_re         = 1'b0;
        mem_raddr      = wrap_pos(head_reg, tail_off);
        req_stall      = (state_reg != ST_IDLE);

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    in_next       = req_data;
                    rc_next       = RC_FAIL;
                    rd_entry_next = '0;
                    state_next    = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (cmd_t'(in_reg.command))
                    CMD_RESET:
                    begin
                        head_next  = '0;
                        count_next = '0;
                        mode_next  = MODE_NORMAL;
                        rc_next    = RC_OK;
                    end

                    CMD_APPEND:
                    begin
                        rc_next = RC_OK;
                        if (count_reg < CAP_CNT)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = wrap_pos(head_reg, (PTR_W + 1)'(count_reg));
                            mem_wdata  = '{word:  in_reg.step_word,
                                           speed: in_reg.speed,
                                           turn:  in_reg.turn_rate,
                                           last:  in_reg.final_flag,
                                           cons:  in_reg.constraint_in};
                            count_next = count_reg + 1'b1;
                        end
                    end

                    CMD_BRAKE, CMD_FINALIZE:
                    begin
                        if (count_reg != '0)
                        begin
                            head_next  = wrap_pos(head_reg, (PTR_W + 1)'(1));
                            count_next = count_reg - 1'b1;
                            // The pop stays done even when the command fails below.
                            if (count_reg != CNT_W'(1))
                            begin
                                zero_vel_next = 1'b0;
                                set_cons_next = 1'b0;
                                pad_idx_next  = count_reg - 1'b1;
                                mem_raddr     = wrap_pos(head_reg, tail_off);
                                if (cmd_t'(in_reg.command) == CMD_BRAKE)
                                begin
                                    mem_re     = 1'b1;
                                    state_next = ST_RDWAIT;
                                    if (mode_reg != MODE_BRAKING)
                                    begin
                                        // Keep only the new head, then pad from it.
                                        mem_raddr     = wrap_pos(head_reg, (PTR_W + 1)'(1));
                                        pad_idx_next  = '0;
                                        zero_vel_next = 1'b1;
                                        set_cons_next = 1'b1;
                                        mode_next     = MODE_BRAKING;
                                    end
                                end
                                else if (mode_reg == MODE_ENDING)
                                begin
                                    mem_re     = 1'b1;
                                    state_next = ST_RDWAIT;
                                end
                                else if (mode_reg == MODE_NORMAL)
                                begin
                                    // A stopped copy of the tail is appended, then repeated.
                                    mem_re        = 1'b1;
                                    zero_vel_next = 1'b1;
                                    mode_next     = MODE_ENDING;
                                    state_next    = ST_RDWAIT;
                                end
                            end
                        end
                    end

                    CMD_CHECK:
                    begin
                        if (mode_reg == MODE_NORMAL)
                        begin
                            if (int'(count_reg) < FILL_MARK)
                            begin
                                rc_next = RC_NODATA;
                            end
                            else if (int'(count_reg) > FILL_MARK)
                            begin
                                rc_next = RC_OK;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = wrap_pos(head_reg, tail_off);
                                state_next = ST_RDWAIT;
                            end
                        end
                    end

                    CMD_READ:
                    begin
                        if (count_reg == '0)
                        begin
                            rc_next = RC_NODATA;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = wrap_pos(head_reg, read_off);
                            state_next = ST_RDWAIT;
                        end
                    end

                    default:
                    begin
                        rc_next = RC_FAIL;
                    end
                endcase
            end

            ST_RDWAIT:
            begin
                state_next = ST_DONE;
                case (cmd_t'(in_reg.command))
                    CMD_CHECK:
                    begin
                        rc_next = mem_rdata_reg.last ? RC_END : RC_NODATA;
                    end

                    CMD_READ:
                    begin
                        rd_entry_next = mem_rdata_reg;
                        rc_next       = RC_OK;
                    end

                    default:
                    begin
                        if (zero_vel_reg)
                        begin
                            pv.speed = '0;
                            pv.turn  = '0;
                        end
                        if (set_cons_reg)
                        begin
                            pv.cons = cfg_reg;
                        end
                        pad_val_next = pv;
                        rc_next      = RC_OK;
                        state_next   = ST_PAD;
                    end
                endcase
            end

            ST_PAD:
            begin
                mem_we       = 1'b1;
                pad_idx_next = pad_idx_reg + 1'b1;
                if (pad_idx_reg == CAP_CNT - 1'b1)
                begin
                    count_next = CAP_CNT;
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_data_next = '{result_code:    rc_reg,
                                      mode_now:       mode_reg,
                                      fill_count:     FILL_W'(count_reg),
                                      step_out:       rd_entry_reg.word,
                                      speed_out:      rd_entry_reg.speed,
                                      turn_out:       rd_entry_reg.turn,
                                      final_out:      rd_entry_reg.last,
                                      constraint_out: rd_entry_reg.cons};
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            mode_reg      <= MODE_NORMAL;
            rsp_valid_reg <= 1'b0;
            cfg_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        rc_reg       <= rc_next;
        rd_entry_reg <= rd_entry_next;
        pad_idx_reg  <= pad_idx_next;
        pad_val_reg  <= pad_val_next;
        zero_vel_reg <= zero_vel_next;
        set_cons_reg <= set_cons_next;
        rsp_data_reg <= rsp_data_next;
    end

    // Step store: one write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count exceeds capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == ST_EXEC)
        else $error("accepted word did not start execution");

    a_mode_change: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != $past(mode_reg) |-> $past(state_reg) == ST_EXEC)
        else $error("mode changed outside command execution");

    a_pad_full: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PAD && state_next == ST_DONE |=> count_reg == CAP_CNT)
        else $error("padding finished without a full store");

    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == ST_EXEC || state_reg == ST_PAD)
        else $error("store written outside execution or padding");

endmodule
